// ===== rtl/core/bb5_pkg.sv =====
`timescale 1ns / 1ps

package bb5_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_WIDTH  = 3;
  localparam int CHANNELS   = 3;

  // sample and pixel layout
  localparam int SAMPLE_W  = 8;
  localparam int RGB_CH    = 3;
  localparam int BUS_W     = RGB_CH * SAMPLE_W;
  localparam int PIX_W     = CHANNELS * SAMPLE_W;
  localparam int TAPS      = 5;
  localparam int ROWS_KEPT = TAPS - 1;
  localparam int SLOT_W    = 2;
  localparam int WORD_W    = ROWS_KEPT * PIX_W;

  // counters and configuration
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 9;
  localparam int DIM_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int ROW_W      = 9;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = CFG_ADDR_W'(1);

  // sums and the divide by 25 as multiply and shift
  localparam int COLSUM_W  = 11;
  localparam int WINSUM_W  = 13;
  localparam int DIV_MUL   = 5243;
  localparam int DIV_SHIFT = 17;
  localparam int PROD_W    = 2 * WINSUM_W;

  // which of an item's results is being formed
  localparam logic [1:0] SEL_FULL  = 2'd0;
  localparam logic [1:0] SEL_DROP1 = 2'd1;
  localparam logic [1:0] SEL_DROP2 = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic c_load;
    logic d_load;
    logic d_clear;
  } lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic main;
    logic row_end;
    logic eof;
  } res_info_t;

endpackage

// ===== rtl/core/bb5_line_store.sv =====
`timescale 1ns / 1ps

module bb5_line_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [bb5_pkg::COL_W-1:0]     rd_addr,
  input  logic                          wr_en,
  input  logic [bb5_pkg::COL_W-1:0]     wr_addr,
  input  logic [bb5_pkg::SLOT_W-1:0]    wr_slot,
  input  logic [bb5_pkg::PIX_W-1:0]     wr_pix,
  output logic [bb5_pkg::WORD_W-1:0]    rd_data,
  output logic                          busy
);
  import bb5_pkg::*;

  logic [WORD_W-1:0] line_mem_r [MAX_WIDTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] wr_word;
  logic [COL_W-1:0]  clr_addr_r;
  logic              busy_r;

  // clearing pass over every column after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= COL_W'(clr_addr_r + 1'b1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // replace the slot of the row being written, keep the other three
  always_comb begin
    wr_word = rd_data_r;
    wr_word[wr_slot * PIX_W +: PIX_W] = wr_pix;
  end

  // column word write
  always_ff @(posedge clk) begin
    if (busy_r) begin
      line_mem_r[clr_addr_r] <= '0;
    end else if (wr_en) begin
      line_mem_r[wr_addr] <= wr_word;
    end
  end

  // registered column read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== rtl/core/bb5_lane.sv =====
`timescale 1ns / 1ps

module bb5_lane (
  input  logic                                        clk,
  input  bb5_pkg::lane_ctl_t                          ctl,
  input  logic [bb5_pkg::ROWS_KEPT-1:0]               slot_en,
  input  logic [bb5_pkg::ROWS_KEPT*bb5_pkg::SAMPLE_W-1:0] slot_px,
  input  bb5_pkg::sample_t                            sample,
  input  logic [1:0]                                  sel,
  output logic [bb5_pkg::WINSUM_W-1:0]                win_sum
);
  import bb5_pkg::*;

  logic [COLSUM_W-1:0] col_sum;
  logic [COLSUM_W-1:0] cs_r;
  logic [COLSUM_W-1:0] win_r [TAPS];
  logic [WINSUM_W-1:0] sum_r;

  // vertical sum of the five rows of this column
  always_comb begin
    col_sum = COLSUM_W'(sample);
    for (int s = 0; s < ROWS_KEPT; s++) begin
      if (slot_en[s]) begin
        col_sum = COLSUM_W'(col_sum + COLSUM_W'(slot_px[s*SAMPLE_W +: SAMPLE_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.c_load) begin
      cs_r <= col_sum;
    end
  end

  // window of column sums with running total, cleared at row start
  always_ff @(posedge clk) begin
    if (ctl.d_load) begin
      if (ctl.d_clear) begin
        for (int t = 0; t < TAPS - 1; t++) begin
          win_r[t] <= '0;
        end
        win_r[TAPS-1] <= cs_r;
        sum_r         <= WINSUM_W'(cs_r);
      end else begin
        for (int t = 0; t < TAPS - 1; t++) begin
          win_r[t] <= win_r[t+1];
        end
        win_r[TAPS-1] <= cs_r;
        sum_r         <= WINSUM_W'(sum_r - WINSUM_W'(win_r[0]) + WINSUM_W'(cs_r));
      end
    end
  end

  // past the row end, zero columns push the oldest ones out
  always_comb begin
    unique case (sel)
      SEL_FULL:  win_sum = sum_r;
      SEL_DROP1: win_sum = WINSUM_W'(sum_r - WINSUM_W'(win_r[0]));
      SEL_DROP2: win_sum = WINSUM_W'(sum_r - WINSUM_W'(win_r[0]) - WINSUM_W'(win_r[1]));
      default:   win_sum = sum_r;
    endcase
  end

endmodule

// ===== rtl/core/bb5_merge.sv =====
`timescale 1ns / 1ps

module bb5_merge (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  bb5_pkg::res_info_t                            info,
  output logic                                          d_ready,
  output logic [1:0]                                    sel,
  input  logic [bb5_pkg::CHANNELS-1:0][bb5_pkg::WINSUM_W-1:0] lane_sum,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [bb5_pkg::BUS_W-1:0]                     out_tdata,  // red_out, green_out, blue_out
  output logic                                          out_tlast,  // last_of_run
  output logic                                          out_tuser   // end_of_frame
);
  import bb5_pkg::*;

  logic             d_valid_r;
  logic             d_main_r;
  logic             d_end_r;
  logic             d_eof_r;
  logic [1:0]       d_idx_r;
  logic             is_last;
  logic             fire;
  logic             d_done;
  logic             d_load;
  logic [BUS_W-1:0] quot;
  logic             out_tvalid_r;
  logic [BUS_W-1:0] out_tdata_r;
  logic             out_tlast_r;
  logic             out_tuser_r;

  // result sequencing: none, one or three results per item
  assign is_last = d_end_r ? (d_idx_r == SEL_DROP2) : 1'b1;
  assign fire    = d_valid_r && d_main_r && (!out_tvalid_r || out_tready);
  assign d_done  = !d_valid_r || !d_main_r || (fire && is_last);
  assign d_load  = info.valid && d_done;
  assign d_ready = d_done;
  assign sel     = d_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      d_idx_r   <= SEL_FULL;
    end else if (d_load) begin
      d_valid_r <= 1'b1;
      d_idx_r   <= SEL_FULL;
    end else if (d_done) begin
      d_valid_r <= 1'b0;
    end else if (fire) begin
      d_idx_r <= 2'(d_idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      d_main_r <= info.main;
      d_end_r  <= info.row_end;
      d_eof_r  <= info.eof;
    end
  end

  // divide each lane sum by 25 via reciprocal multiply
  for (genvar gc = 0; gc < RGB_CH; gc++) begin : g_div
    if (gc < CHANNELS) begin : g_lane
      logic [PROD_W-1:0] prod;
      assign prod = PROD_W'(lane_sum[gc]) * PROD_W'(DIV_MUL);
      assign quot[gc*SAMPLE_W +: SAMPLE_W] = prod[DIV_SHIFT +: SAMPLE_W];
    end else begin : g_none
      assign quot[gc*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= quot;
      out_tlast_r <= is_last;
      out_tuser_r <= d_eof_r && d_end_r && is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/core/box_blur_5x5.sv =====
`timescale 1ns / 1ps

// 5x5 mean filter over a raster RGB pixel stream. A frame arrives row by row,
// frame_width pixels per row and frame_height rows, then two more rows of
// padding transactions; each result is the per-channel truncated mean (sum/25)
// of the 5x5 neighborhood, with pixels outside the frame counted as zero. The
// result for a centre pixel leaves once the pixel two rows down and two
// columns right (clamped to the row end) has been taken, so the last pixel of
// a row from the third row on releases three results, tlast marking the last
// result of each input and tuser the frame's final pixel. While out_tready is
// high, one pixel is taken and one result moved per clock, so each of those
// row ends holds in_tready low until its extra results have left. An accepted
// input passes the read, column sum and window stages to the output register.
// After reset the line store is cleared, one column per cycle, over all
// MAX_WIDTH (256) columns, with in_tready low; configuration writes are taken
// at any time and are meant to be written only while idle.
module box_blur_5x5 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bb5_pkg::BUS_W-1:0]        in_tdata,   // red_in, green_in, blue_in
  input  logic                             in_tuser,   // padding
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bb5_pkg::BUS_W-1:0]        out_tdata,  // red_out, green_out, blue_out
  output logic                             out_tlast,  // last_of_run
  output logic                             out_tuser,  // end_of_frame
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb5_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bb5_pkg::CFG_W-1:0]        cfg_data
);
  import bb5_pkg::*;

  logic [CFG_W-1:0]  frame_width_r;
  logic [CFG_W-1:0]  frame_height_r;
  logic [DIM_W-1:0]  eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [ROW_W-1:0]  h_lim;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [DIM_W-1:0]  cur_c;
  logic [ROW_W-1:0]  cur_r;
  logic [DIM_W-1:0]  step_c;
  logic [ROW_W-1:0]  step_r;
  logic [PIX_W-1:0]  a_sample;
  logic              busy;
  logic              acc;
  logic              b_ready;
  logic              c_ready;
  logic              b_move;
  logic              d_ready;
  logic              b_valid_r;
  logic [COL_W-1:0]  b_col_r;
  logic [ROW_W-1:0]  b_row_r;
  logic [PIX_W-1:0]  b_sample_r;
  logic              b_main_r;
  logic              b_end_r;
  logic              b_eof_r;
  logic              b_clr_r;
  logic              c_valid_r;
  logic              c_main_r;
  logic              c_end_r;
  logic              c_eof_r;
  logic              c_clr_r;
  logic [WORD_W-1:0] rd_data;
  logic [ROWS_KEPT-1:0] slot_en;
  logic [1:0]        sel;
  lane_ctl_t         lane_ctl;
  res_info_t         info;
  logic [CHANNELS-1:0][ROWS_KEPT*SAMPLE_W-1:0] lane_px;
  logic [CHANNELS-1:0][WINSUM_W-1:0]           lane_sum;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(MAX_WIDTH);
      frame_height_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame size to the supported range
  always_comb begin
    eff_w = DIM_W'(frame_width_r);
    if (eff_w < DIM_W'(MIN_WIDTH)) eff_w = DIM_W'(MIN_WIDTH);
    if (eff_w > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = ROW_W'(frame_height_r);
    if (frame_height_r == '0) eff_h = ROW_W'(1);
    if (frame_height_r > CFG_W'(MAX_HEIGHT)) eff_h = ROW_W'(MAX_HEIGHT);
    h_lim = ROW_W'(eff_h + ROW_W'(2));
  end

  // position of the incoming pixel and of the one after it
  always_comb begin
    cur_c = DIM_W'(col_r);
    cur_r = row_r;
    if (DIM_W'(col_r) >= eff_w) begin
      cur_c = '0;
      cur_r = ROW_W'(row_r + 1'b1);
    end
    if (cur_r >= h_lim) cur_r = '0;
    step_c = DIM_W'(cur_c + 1'b1);
    step_r = cur_r;
    if (step_c >= eff_w) begin
      step_c = '0;
      step_r = ROW_W'(cur_r + 1'b1);
      if (step_r >= h_lim) step_r = '0;
    end
    col_nxt = step_c[COL_W-1:0];
    row_nxt = step_r;
  end

  // padding transactions and padding rows carry zero samples
  assign a_sample = (in_tuser || cur_r >= eff_h) ? '0 : in_tdata[PIX_W-1:0];

  // pipeline handshake
  assign c_ready   = !c_valid_r || d_ready;
  assign b_ready   = !b_valid_r || c_ready;
  assign b_move    = b_valid_r && c_ready;
  assign in_tready = !busy && b_ready;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (acc) begin
      b_valid_r <= 1'b1;
    end else if (b_move) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_col_r    <= cur_c[COL_W-1:0];
      b_row_r    <= cur_r;
      b_sample_r <= a_sample;
      b_main_r   <= (cur_r >= ROW_W'(2)) && (cur_c >= DIM_W'(2));
      b_end_r    <= (cur_r >= ROW_W'(2)) && (cur_c == DIM_W'(eff_w - 1'b1));
      b_eof_r    <= (cur_r == ROW_W'(eff_h + 1'b1));
      b_clr_r    <= (cur_c == '0);
    end
  end

  // column sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (b_move) begin
      c_valid_r <= 1'b1;
    end else if (d_ready) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_main_r <= b_main_r;
      c_end_r  <= b_end_r;
      c_eof_r  <= b_eof_r;
      c_clr_r  <= b_clr_r;
    end
  end

  bb5_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (cur_c[COL_W-1:0]),
    .wr_en   (b_move),
    .wr_addr (b_col_r),
    .wr_slot (b_row_r[SLOT_W-1:0]),
    .wr_pix  (b_sample_r),
    .rd_data (rd_data),
    .busy    (busy)
  );

  // rows above the frame top are masked out of the column
  always_comb begin
    slot_en = '0;
    for (int k = 1; k <= ROWS_KEPT; k++) begin
      slot_en[SLOT_W'(b_row_r - ROW_W'(k))] = (b_row_r >= ROW_W'(k));
    end
  end

  // split the column word per channel
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int s = 0; s < ROWS_KEPT; s++) begin
        lane_px[ch][s*SAMPLE_W +: SAMPLE_W] = rd_data[s*PIX_W + ch*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  assign lane_ctl.c_load  = b_move;
  assign lane_ctl.d_load  = c_valid_r && d_ready;
  assign lane_ctl.d_clear = c_clr_r;

  for (genvar gl = 0; gl < CHANNELS; gl++) begin : g_lane
    bb5_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .slot_en (slot_en),
      .slot_px (lane_px[gl]),
      .sample  (b_sample_r[gl*SAMPLE_W +: SAMPLE_W]),
      .sel     (sel),
      .win_sum (lane_sum[gl])
    );
  end

  assign info.valid   = c_valid_r;
  assign info.main    = c_main_r;
  assign info.row_end = c_end_r;
  assign info.eof     = c_eof_r;

  bb5_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .info       (info),
    .d_ready    (d_ready),
    .sel        (sel),
    .lane_sum   (lane_sum),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // frame end only on the final result of the last pixel
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of frame without last of run");

  // column counter stays inside the row after each transaction
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> DIM_W'(col_r) < $past(eff_w))
    else $error("column counter beyond row width");

  // the clearing pass never overlaps a pipeline write
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !b_valid_r && !c_valid_r)
    else $error("pixel in flight during line store clearing");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bb5_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 50;
  localparam int NOISE_PCT    = 8;

  // index that maps to no register, writes to it must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = CFG_ADDR_W'(3);

  typedef struct packed {
    logic [BUS_W-1:0] rgb;
    logic             pad;
  } pixel_item_t;

  typedef struct packed {
    logic [BUS_W-1:0] px;
    logic             last;
    logic             eof;
  } blur_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BUS_W-1:0]      in_tdata = '0;   // red_in, green_in, blue_in
  logic                  in_tuser = 1'b0; // padding
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BUS_W-1:0]      out_tdata;       // red_out, green_out, blue_out
  logic                  out_tlast;       // last_of_run
  logic                  out_tuser;       // end_of_frame
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  box_blur_5x5 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  pixel_item_t pixel_queue[$];
  blur_res_t   blur_expect[$];
  int          errors = 0;
  int          stuck_cycles = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          calm = 1'b0;
  pixel_item_t next_pix;

  // predictor state
  logic [PIX_W-1:0] line_mem [MAX_WIDTH*ROWS_KEPT];
  logic [PIX_W-1:0] win [TAPS*TAPS];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic clear_model();
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = CFG_W'(MAX_WIDTH);
    height_reg = CFG_W'(MAX_HEIGHT);
  endtask

  // window row 0 is the oldest row, column 0 the leftmost
  task automatic shift_window(input logic [PIX_W-1:0] colv [TAPS]);
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS - 1; c++) win[r*TAPS + c] = win[r*TAPS + c + 1];
      win[r*TAPS + TAPS - 1] = colv[r];
    end
  endtask

  function automatic blur_res_t window_mean(logic eof);
    blur_res_t res;
    int        sum;
    res = '0;
    for (int ch = 0; ch < RGB_CH; ch++) begin
      sum = 0;
      for (int i = 0; i < TAPS*TAPS; i++) sum += win[i][SAMPLE_W*ch +: SAMPLE_W];
      if (ch < CHANNELS) res.px[SAMPLE_W*ch +: SAMPLE_W] = SAMPLE_W'(sum / (TAPS*TAPS));
    end
    res.eof = eof;
    return res;
  endfunction

  // one accepted pixel: update position, line store and window, queue results
  task automatic blur_accept(input logic [BUS_W-1:0] rgb, input logic pad);
    int unsigned      w, h, c, r, n;
    logic [PIX_W-1:0] samp;
    logic [PIX_W-1:0] colv [TAPS];
    logic [PIX_W-1:0] zcol [TAPS];
    blur_res_t        res [3];
    w = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
        (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    n = 0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h + 2) row_pos = 0;
    c = col_pos;
    r = row_pos;

    samp = '0;
    for (int ch = 0; ch < CHANNELS; ch++)
      samp[SAMPLE_W*ch +: SAMPLE_W] = rgb[SAMPLE_W*ch +: SAMPLE_W];
    if (pad || r >= h) samp = '0;

    if (c == 0) foreach (win[i]) win[i] = '0;
    for (int k = ROWS_KEPT; k >= 1; k--)
      colv[ROWS_KEPT - k] = (r >= k) ? line_mem[c*ROWS_KEPT + ((r - k) & 3)] : '0;
    colv[TAPS-1] = samp;
    line_mem[c*ROWS_KEPT + (r & 3)] = samp;
    shift_window(colv);

    if (r >= 2) begin
      foreach (zcol[i]) zcol[i] = '0;
      if (c >= 2) begin
        res[n] = window_mean(1'b0);
        n++;
      end
      // row end flushes the two centres to its left
      if (c == w - 1) begin
        shift_window(zcol);
        res[n] = window_mean(1'b0);
        n++;
        shift_window(zcol);
        res[n] = window_mean(r == h + 1);
        n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) blur_expect.push_back(res[i]);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h + 2) row_pos = 0;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) in_gap = calm ? 0 : $urandom_range(0, 3);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        next_pix = pixel_queue.pop_front();
        in_tdata  <= next_pix.rgb;
        in_tuser  <= next_pix.pad;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_stall = calm ? 0 : $urandom_range(0, 3);
      else if (out_stall > 0) out_stall--;
      out_tready <= (out_stall == 0);
    end
  end

  // monitor: predict on every transaction in, check every transaction out
  always @(posedge clk) begin
    blur_res_t want;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_addr == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (in_tvalid && in_tready) blur_accept(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (blur_expect.size() == 0) begin
          $error("out_tdata: no result expected, got %h", out_tdata);
          errors++;
        end else begin
          want = blur_expect.pop_front();
          if (out_tdata[7:0] !== want.px[7:0]) begin
            $error("red_out: expected %0d, got %0d", want.px[7:0], out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[15:8] !== want.px[15:8]) begin
            $error("green_out: expected %0d, got %0d", want.px[15:8], out_tdata[15:8]);
            errors++;
          end
          if (out_tdata[23:16] !== want.px[23:16]) begin
            $error("blue_out: expected %0d, got %0d", want.px[23:16], out_tdata[23:16]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
            errors++;
          end
          if (out_tuser !== want.eof) begin
            $error("end_of_frame: expected %0d, got %0d", want.eof, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_tvalid || blur_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_pix(input logic [BUS_W-1:0] rgb, input logic pad);
    pixel_queue.push_back('{rgb: rgb, pad: pad});
  endtask

  function automatic logic [BUS_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BUS_W'($urandom);
    endcase
  endfunction

  // well-formed rows of a frame, with an occasional flipped padding flag
  task automatic queue_rows(input int w, input int h, input int first_row, input int n_rows,
                            input int noise);
    logic pad;
    for (int r = first_row; r < first_row + n_rows; r++) begin
      for (int c = 0; c < w; c++) begin
        pad = (r >= h);
        if ($urandom_range(0, 99) < noise) pad = ~pad;
        queue_pix(rand_pixel(), pad);
      end
    end
  endtask

  initial begin
    int fw, fh, ew, eh, random_count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: widths and heights below range clamp to 3 x 1, spare index ignored
    write_reg(REG_FRAME_WIDTH, CFG_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
    write_reg(REG_SPARE, '1);
    // full-scale row, padding row with data, then non-padding items in a padding row
    repeat (3) queue_pix('1, 1'b0);
    repeat (3) queue_pix('1, 1'b1);
    repeat (3) queue_pix('1, 1'b0);
    // zero pixel, padding flag inside the frame, mixed pixel
    queue_pix('0, 1'b0);
    queue_pix('1, 1'b1);
    queue_pix(24'h80FF01, 1'b0);
    repeat (6) queue_pix(rand_pixel(), 1'b1);
    wait_idle();

    // random small frames
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      fh = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
      write_reg(REG_FRAME_WIDTH, CFG_W'(fw));
      write_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 511)));
      calm = ($urandom_range(0, 3) == 0);
      ew = (fw < MIN_WIDTH) ? MIN_WIDTH : fw;
      eh = (fh < 1) ? 1 : fh;
      repeat ($urandom_range(1, 2)) begin
        queue_rows(ew, eh, 0, eh + 2, NOISE_PCT);
        random_count += ew * (eh + 2);
      end
      wait_idle();
    end
    calm = 1'b0;

    // oversized registers, then shrink the width mid-row so the column wraps
    write_reg(REG_FRAME_WIDTH, CFG_W'(511));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(511));
    queue_rows(MAX_WIDTH, MAX_HEIGHT, 0, 1, 0);
    repeat (MAX_WIDTH - 20) void'(pixel_queue.pop_back());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(5));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    queue_rows(5, 2, 1, 3, 0);
    wait_idle();

    // shrink the height once the row counter sits in the padding rows
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
    queue_rows(4, 4, 0, 5, 0);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
    queue_rows(4, 1, 0, 3, 0);
    wait_idle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
